// ----- design/ucs_pkg.sv -----
// Package for the URI component splitter: character codes, part identifiers,
// datapath command and status types and the character-class function.
// No dependencies.
package ucs_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam logic [2:0] PART_SCHEME = 3'd0;
  localparam logic [2:0] PART_USER   = 3'd1;
  localparam logic [2:0] PART_HOST   = 3'd2;
  localparam logic [2:0] PART_PORT   = 3'd3;
  localparam logic [2:0] PART_QUERY  = 3'd4;
  localparam logic [2:0] PART_FRAG   = 3'd5;
  localparam logic [2:0] PART_PATH   = 3'd6;
  localparam logic [2:0] PART_DONE   = 3'd7;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INC,
    CMD_SCHEME_END,
    CMD_NOAUTH,
    CMD_AUTH,
    CMD_HOST_BEGIN,
    CMD_AT,
    CMD_COLON,
    CMD_QMARK_AUTH,
    CMD_HASH_AUTH,
    CMD_SLASH,
    CMD_NUL,
    CMD_END_AUTH,
    CMD_TAIL_Q,
    CMD_HASH_TAIL,
    CMD_TAIL_END,
    CMD_CK_START,
    CMD_CK_NEXT,
    CMD_HOST_BR,
    CMD_EMIT,
    CMD_FAIL_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    ADDR_I,
    ADDR_I_PLUS,
    ADDR_I_MINUS,
    ADDR_HOST
  } addr_sel_t;

  typedef struct packed {
    dp_op_t    op;
    addr_sel_t asel;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       i_ge_n;
    logic       i_zero;
    logic       i1_lt_n;
    logic       skip;
    logic       ck_done;
    logic       ck_last;
    logic       ck_ok;
    logic       emit_last;
    logic       out_free;
    logic       ovf_now;
  } dp_status_t;

  // Character classes of the scheme, userinfo, host and port parts.
  function automatic logic class_ok(input logic [2:0] part, input logic [7:0] c);
    logic alnum;
    logic base;
    logic res;
    alnum = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    base  = alnum || (c inside {8'h21, [8'h24:8'h2E], 8'h3A, 8'h3B, 8'h3D, 8'h5F, 8'h7E});
    case (part)
      PART_PORT:   res = c inside {[8'h30:8'h39]};
      PART_SCHEME: res = alnum || (c inside {8'h2B, 8'h2D, 8'h2E});
      PART_HOST:   res = base || (c inside {CH_LBRACK, CH_RBRACK});
      default:     res = base;
    endcase
    return res;
  endfunction

endpackage

// ----- design/ucs_channels.sv -----
// Stream interfaces of the URI component splitter: the text channel that
// carries one byte per transaction and the channel that carries part results.
// No dependencies.
interface ucs_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface ucs_part_if;
  logic       valid;
  logic       ready;
  logic [2:0] part_id;
  logic [8:0] part_start;
  logic [8:0] part_length;
  logic       ok;
  logic       out_last;
  modport source(output valid, part_id, part_start, part_length, ok, out_last,
                 input ready);
  modport sink(input valid, part_id, part_start, part_length, ok, out_last,
               output ready);
endinterface

// ----- design/ucs_ctrl.sv -----
// Controller of the URI component splitter: sequences loading, the boundary
// scans, the character-class pass and result emission.
// Depends on ucs_pkg.
module ucs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output ucs_pkg::dp_cmd_t     cmd,
  input  ucs_pkg::dp_status_t  status
);

  typedef enum logic [26:0] {
    ST_LOAD     = 27'd1 << 0,
    ST_SC_RD    = 27'd1 << 1,
    ST_SC_EV    = 27'd1 << 2,
    ST_AU0_RD   = 27'd1 << 3,
    ST_AU0_EV   = 27'd1 << 4,
    ST_AU1_RD   = 27'd1 << 5,
    ST_AU1_EV   = 27'd1 << 6,
    ST_AU2_RD   = 27'd1 << 7,
    ST_AU2_EV   = 27'd1 << 8,
    ST_LP_RD    = 27'd1 << 9,
    ST_LP_EV    = 27'd1 << 10,
    ST_AT_RD    = 27'd1 << 11,
    ST_AT_EV    = 27'd1 << 12,
    ST_CO_RD    = 27'd1 << 13,
    ST_CO_EV    = 27'd1 << 14,
    ST_END_AUTH = 27'd1 << 15,
    ST_TL_RD    = 27'd1 << 16,
    ST_TL_EV    = 27'd1 << 17,
    ST_QW_CHK   = 27'd1 << 18,
    ST_QW_EV    = 27'd1 << 19,
    ST_CK_INIT  = 27'd1 << 20,
    ST_CK_RD    = 27'd1 << 21,
    ST_CK_EV    = 27'd1 << 22,
    ST_HB_RD    = 27'd1 << 23,
    ST_HB_EV    = 27'd1 << 24,
    ST_EMIT     = 27'd1 << 25,
    ST_FAIL     = 27'd1 << 26
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = ucs_pkg::CMD_NONE;
    cmd.asel   = ucs_pkg::ADDR_I;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ucs_pkg::CMD_LOAD;
          if (in_last) begin
            state_next = status.ovf_now ? ST_FAIL : ST_SC_RD;
          end
        end
      end
      ST_SC_RD: state_next = ST_SC_EV;
      ST_SC_EV: begin
        if (status.i_ge_n) begin
          state_next = ST_FAIL;
        end else if (status.ch == ucs_pkg::CH_COLON) begin
          if (status.i_zero) begin
            state_next = ST_FAIL;
          end else begin
            cmd.op     = ucs_pkg::CMD_SCHEME_END;
            state_next = ST_AU0_RD;
          end
        end else begin
          cmd.op     = ucs_pkg::CMD_INC;
          state_next = ST_SC_RD;
        end
      end
      ST_AU0_RD: state_next = ST_AU0_EV;
      ST_AU0_EV: begin
        if (status.ch == ucs_pkg::CH_SLASH) begin
          state_next = ST_AU1_RD;
        end else begin
          cmd.op     = ucs_pkg::CMD_NOAUTH;
          state_next = ST_END_AUTH;
        end
      end
      ST_AU1_RD: begin
        cmd.asel   = ucs_pkg::ADDR_I_PLUS;
        state_next = ST_AU1_EV;
      end
      ST_AU1_EV: begin
        if (status.ch == ucs_pkg::CH_SLASH) begin
          cmd.op     = ucs_pkg::CMD_AUTH;
          state_next = ST_AU2_RD;
        end else begin
          cmd.op     = ucs_pkg::CMD_NOAUTH;
          state_next = ST_END_AUTH;
        end
      end
      ST_AU2_RD: state_next = ST_AU2_EV;
      ST_AU2_EV: begin
        cmd.op     = ucs_pkg::CMD_HOST_BEGIN;
        state_next = ST_LP_RD;
      end
      ST_LP_RD: state_next = ST_LP_EV;
      ST_LP_EV: begin
        case (status.ch)
          ucs_pkg::CH_AT:    state_next = ST_AT_RD;
          ucs_pkg::CH_COLON: state_next = ST_CO_RD;
          ucs_pkg::CH_QMARK: begin
            cmd.op     = ucs_pkg::CMD_QMARK_AUTH;
            state_next = ST_LP_RD;
          end
          ucs_pkg::CH_HASH: begin
            cmd.op     = ucs_pkg::CMD_HASH_AUTH;
            state_next = ST_CK_INIT;
          end
          ucs_pkg::CH_SLASH: begin
            cmd.op     = ucs_pkg::CMD_SLASH;
            state_next = status.skip ? ST_LP_RD : ST_END_AUTH;
          end
          ucs_pkg::CH_NUL: begin
            cmd.op     = ucs_pkg::CMD_NUL;
            state_next = ST_END_AUTH;
          end
          default: begin
            cmd.op     = ucs_pkg::CMD_INC;
            state_next = ST_LP_RD;
          end
        endcase
      end
      ST_AT_RD: begin
        cmd.asel   = ucs_pkg::ADDR_I_PLUS;
        state_next = ST_AT_EV;
      end
      ST_AT_EV: begin
        cmd.op     = ucs_pkg::CMD_AT;
        state_next = ST_LP_RD;
      end
      ST_CO_RD: begin
        cmd.asel   = ucs_pkg::ADDR_I_MINUS;
        state_next = ST_CO_EV;
      end
      ST_CO_EV: begin
        cmd.op     = ucs_pkg::CMD_COLON;
        state_next = ST_LP_RD;
      end
      ST_END_AUTH: begin
        cmd.op     = ucs_pkg::CMD_END_AUTH;
        state_next = status.skip ? ST_CK_INIT : ST_TL_RD;
      end
      ST_TL_RD: state_next = ST_TL_EV;
      ST_TL_EV: begin
        if (status.i_ge_n) begin
          cmd.op     = ucs_pkg::CMD_TAIL_END;
          state_next = ST_CK_INIT;
        end else if (status.ch == ucs_pkg::CH_QMARK) begin
          cmd.op     = ucs_pkg::CMD_TAIL_Q;
          state_next = ST_QW_CHK;
        end else if (status.ch == ucs_pkg::CH_HASH) begin
          cmd.op     = ucs_pkg::CMD_HASH_TAIL;
          state_next = ST_CK_INIT;
        end else begin
          cmd.op     = ucs_pkg::CMD_INC;
          state_next = ST_TL_RD;
        end
      end
      ST_QW_CHK: begin
        // Step forward and read the byte stepped onto; stay in this loop while a byte remains.
        cmd.op   = ucs_pkg::CMD_INC;
        cmd.asel = ucs_pkg::ADDR_I_PLUS;
        state_next = status.i1_lt_n ? ST_QW_EV : ST_TL_RD;
      end
      ST_QW_EV: begin
        if (status.ch == ucs_pkg::CH_HASH) begin
          cmd.op     = ucs_pkg::CMD_HASH_TAIL;
          state_next = ST_CK_INIT;
        end else begin
          state_next = ST_QW_CHK;
        end
      end
      ST_CK_INIT: begin
        cmd.op     = ucs_pkg::CMD_CK_START;
        state_next = ST_CK_RD;
      end
      ST_CK_RD: begin
        if (status.ck_done) begin
          if (status.ck_last) begin
            state_next = ST_HB_RD;
          end else begin
            cmd.op = ucs_pkg::CMD_CK_NEXT;
          end
        end else begin
          state_next = ST_CK_EV;
        end
      end
      ST_CK_EV: begin
        if (!status.ck_ok) begin
          state_next = ST_FAIL;
        end else begin
          cmd.op     = ucs_pkg::CMD_INC;
          state_next = ST_CK_RD;
        end
      end
      ST_HB_RD: begin
        cmd.asel   = ucs_pkg::ADDR_HOST;
        state_next = ST_HB_EV;
      end
      ST_HB_EV: begin
        cmd.op     = ucs_pkg::CMD_HOST_BR;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op = ucs_pkg::CMD_EMIT;
          if (status.emit_last) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_FAIL: begin
        if (status.out_free) begin
          cmd.op     = ucs_pkg::CMD_FAIL_OUT;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ----- design/ucs_datapath.sv -----
// Datapath of the URI component splitter: text store, scan index, part
// boundary registers, character-class check and the result register.
// Depends on ucs_pkg.
module ucs_datapath #(
  parameter int MAX_LEN = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  ucs_pkg::dp_cmd_t    cmd,
  output ucs_pkg::dp_status_t status,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          part_id,
  output logic [8:0]          part_start,
  output logic [8:0]          part_length,
  output logic                ok,
  output logic                out_last
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int IW = $clog2(MAX_LEN) + 2;

  logic [7:0]    mem [MAX_LEN];
  logic [7:0]    rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_addr_q;

  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic          zero_seen;
  logic          overflow;

  logic [IW-1:0] i;
  logic [IW-1:0] sb [8];
  logic [IW-1:0] se [8];
  logic [2:0]    pre;
  logic          ipv6;
  logic          skip;
  logic [2:0]    p;
  logic          host_br;

  logic [IW-1:0] n_i;
  logic [IW-1:0] i_plus;
  logic [7:0]    ch;
  logic          colon_v6;
  logic          clear_text;
  logic          store_ok;
  logic [IW-1:0] em_s;
  logic [IW-1:0] em_e;
  logic [IW-1:0] em_len;
  logic [IW-1:0] em_start;
  logic [IW-1:0] em_length;

  assign n_i      = IW'(n);
  assign i_plus   = i + IW'(1);
  assign store_ok = count < CW'(MAX_LEN);

  always_comb begin
    case (cmd.asel)
      ucs_pkg::ADDR_I_PLUS:  rd_addr = i_plus;
      ucs_pkg::ADDR_I_MINUS: rd_addr = i - IW'(1);
      ucs_pkg::ADDR_HOST:    rd_addr = sb[ucs_pkg::PART_HOST];
      default:               rd_addr = i;
    endcase
  end

  // Text store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == ucs_pkg::CMD_LOAD && store_ok) begin
      mem[count[AW-1:0]] <= in_byte;
    end
    rd_data   <= mem[rd_addr[AW-1:0]];
    rd_addr_q <= rd_addr;
  end

  // Bytes at or past the first zero byte read as zero.
  assign ch       = (rd_addr_q < n_i) ? rd_data : ucs_pkg::CH_NUL;
  assign colon_v6 = (ch == ucs_pkg::CH_RBRACK) ? 1'b0 : ipv6;

  // Result fields of the part selected by p.
  always_comb begin
    em_s   = sb[p];
    em_e   = se[p];
    em_len = (em_e > em_s) ? em_e - em_s : '0;
    em_start  = em_s;
    em_length = em_len;
    if (p == ucs_pkg::PART_HOST && em_len != '0 && host_br) begin
      em_start  = em_s + IW'(1);
      em_length = (em_len >= IW'(2)) ? em_len - IW'(2) : '0;
    end
    if (em_length == '0) begin
      em_start = '0;
    end
  end

  assign clear_text = (cmd.op == ucs_pkg::CMD_FAIL_OUT) ||
                      (cmd.op == ucs_pkg::CMD_EMIT && p == ucs_pkg::PART_PATH);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      n         <= '0;
      zero_seen <= 1'b0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ucs_pkg::CMD_LOAD) begin
        if (store_ok) begin
          count <= count + CW'(1);
          if (!zero_seen) begin
            if (in_byte == ucs_pkg::CH_NUL) begin
              zero_seen <= 1'b1;
            end else begin
              n <= n + CW'(1);
            end
          end
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.op == ucs_pkg::CMD_EMIT || cmd.op == ucs_pkg::CMD_FAIL_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear_text) begin
        count     <= '0;
        n         <= '0;
        zero_seen <= 1'b0;
        overflow  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ucs_pkg::CMD_LOAD: begin
        if (in_last) begin
          for (int k = 0; k < 8; k++) begin
            sb[k] <= '0;
            se[k] <= '0;
          end
          i    <= '0;
          pre  <= ucs_pkg::PART_PATH;
          ipv6 <= 1'b0;
          skip <= 1'b0;
        end
      end
      ucs_pkg::CMD_INC: i <= i_plus;
      ucs_pkg::CMD_SCHEME_END: begin
        se[ucs_pkg::PART_SCHEME] <= i;
        i <= i_plus;
      end
      ucs_pkg::CMD_NOAUTH: begin
        pre <= ucs_pkg::PART_PATH;
        sb[ucs_pkg::PART_PATH] <= i;
      end
      ucs_pkg::CMD_AUTH: begin
        pre <= ucs_pkg::PART_HOST;
        i   <= i + IW'(2);
      end
      ucs_pkg::CMD_HOST_BEGIN: begin
        if (ch == ucs_pkg::CH_LBRACK) begin
          ipv6 <= 1'b1;
        end else begin
          sb[ucs_pkg::PART_USER] <= i;
        end
        sb[ucs_pkg::PART_HOST] <= i;
      end
      ucs_pkg::CMD_AT: begin
        if (ch == ucs_pkg::CH_LBRACK) begin
          ipv6 <= 1'b1;
        end
        se[ucs_pkg::PART_USER] <= i;
        sb[ucs_pkg::PART_HOST] <= i_plus;
        pre <= ucs_pkg::PART_HOST;
        i   <= i_plus;
      end
      ucs_pkg::CMD_COLON: begin
        ipv6 <= colon_v6;
        if (!colon_v6) begin
          se[ucs_pkg::PART_HOST] <= i;
          sb[ucs_pkg::PART_PORT] <= i_plus;
          pre <= ucs_pkg::PART_PORT;
        end
        i <= i_plus;
      end
      ucs_pkg::CMD_QMARK_AUTH: begin
        se[pre] <= i;
        sb[ucs_pkg::PART_QUERY] <= i_plus;
        pre  <= ucs_pkg::PART_QUERY;
        skip <= 1'b1;
        i    <= i_plus;
      end
      ucs_pkg::CMD_HASH_AUTH: begin
        se[pre] <= i;
        sb[ucs_pkg::PART_FRAG] <= i_plus;
        se[ucs_pkg::PART_FRAG] <= n_i;
        pre  <= ucs_pkg::PART_DONE;
        skip <= 1'b1;
      end
      ucs_pkg::CMD_SLASH: begin
        if (!skip) begin
          sb[ucs_pkg::PART_PATH] <= i;
        end else begin
          i <= i_plus;
        end
      end
      ucs_pkg::CMD_NUL: skip <= 1'b1;
      ucs_pkg::CMD_END_AUTH: begin
        if (pre != ucs_pkg::PART_DONE) begin
          se[pre] <= i;
        end
        if (!skip) begin
          pre <= ucs_pkg::PART_PATH;
        end
      end
      ucs_pkg::CMD_TAIL_Q: begin
        se[ucs_pkg::PART_PATH] <= i;
        sb[ucs_pkg::PART_QUERY] <= i_plus;
        pre <= ucs_pkg::PART_QUERY;
      end
      ucs_pkg::CMD_HASH_TAIL: begin
        se[pre] <= i;
        sb[ucs_pkg::PART_FRAG] <= i_plus;
        se[ucs_pkg::PART_FRAG] <= n_i;
        pre <= ucs_pkg::PART_FRAG;
      end
      ucs_pkg::CMD_TAIL_END: se[pre] <= n_i;
      ucs_pkg::CMD_CK_START: begin
        p <= ucs_pkg::PART_SCHEME;
        i <= sb[ucs_pkg::PART_SCHEME];
      end
      ucs_pkg::CMD_CK_NEXT: begin
        p <= p + 3'd1;
        i <= sb[p + 3'd1];
      end
      ucs_pkg::CMD_HOST_BR: begin
        host_br <= (ch == ucs_pkg::CH_LBRACK);
        p       <= ucs_pkg::PART_SCHEME;
      end
      ucs_pkg::CMD_EMIT: begin
        part_id     <= p;
        part_start  <= 9'(em_start);
        part_length <= 9'(em_length);
        ok          <= 1'b1;
        out_last    <= (p == ucs_pkg::PART_PATH);
        p           <= p + 3'd1;
      end
      ucs_pkg::CMD_FAIL_OUT: begin
        part_id     <= ucs_pkg::PART_SCHEME;
        part_start  <= '0;
        part_length <= '0;
        ok          <= 1'b0;
        out_last    <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status.ch        = ch;
  assign status.i_ge_n    = i >= n_i;
  assign status.i_zero    = i == '0;
  assign status.i1_lt_n   = i_plus < n_i;
  assign status.skip      = skip;
  assign status.ck_done   = i >= se[p];
  assign status.ck_last   = p == ucs_pkg::PART_PORT;
  assign status.ck_ok     = ucs_pkg::class_ok(p, ch);
  assign status.emit_last = p == ucs_pkg::PART_PATH;
  assign status.out_free  = !out_valid || out_ready;
  assign status.ovf_now   = overflow || !store_ok;

endmodule

// ----- design/uri_component_splitter.sv -----
// Loading takes one byte per transaction; after the last byte the controller
// scans the scheme, authority and tail, then checks each part byte against its
// character class, then emits one result per cycle while the output is free.
// Throughput: one URI at a time; the single read port of the text store sets
// the read-then-evaluate step. Reset clears the controller and the byte count; the
// text store itself is never cleared and holds no valid bits.
module uri_component_splitter #(
  parameter int MAX_LEN = 256
) (
  input logic           clk,
  input logic           rst,
  ucs_text_if.sink      text,
  ucs_part_if.source    parts
);

  // The controller steps through the parse as a sequence of read and
  // evaluate states. Every read of the text store is issued in one cycle
  // and its registered data is evaluated in the next.
  ucs_pkg::dp_cmd_t    cmd;
  ucs_pkg::dp_status_t status;

  ucs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_last  (text.in_last),
    .in_ready (text.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the text, the part boundaries and the result
  // register, which lets a result wait while the next URI loads.
  ucs_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_byte     (text.in_byte),
    .in_last     (text.in_last),
    .out_ready   (parts.ready),
    .out_valid   (parts.valid),
    .part_id     (parts.part_id),
    .part_start  (parts.part_start),
    .part_length (parts.part_length),
    .ok          (parts.ok),
    .out_last    (parts.out_last)
  );

  // A failed parse produces exactly one transaction, which closes the URI.
  assert property (@(posedge clk) disable iff (rst)
    parts.valid && !parts.ok |-> parts.out_last)
    else $error("failed parse result does not close the URI");

  // On success only the path part closes the URI.
  assert property (@(posedge clk) disable iff (rst)
    parts.valid && parts.ok |-> (parts.out_last == (parts.part_id == ucs_pkg::PART_PATH)))
    else $error("out_last does not match the path part");

  // An empty part always reports offset zero.
  assert property (@(posedge clk) disable iff (rst)
    parts.valid && parts.ok && parts.part_length == 9'd0 |-> parts.part_start == 9'd0)
    else $error("empty part has a nonzero start");

endmodule
